### rtl/core/bpsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsc_pkg: shared constants for the battery power switch controller
// Field widths, timing windows, register indexes, reset limits, level codes.
// ----------------------------------------------------------------------------
package bpsc_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int NOW_W         = 32;
  localparam int SUM_W         = 14;
  localparam int LVL_W         = 3;
  localparam int CFG_IDX_W     = 3;

  // timing windows in ms (strictly greater than triggers)
  localparam logic [31:0] DEBOUNCE_MS = 32'd50;
  localparam logic [31:0] HOLD_MS     = 32'd3000;
  localparam logic [31:0] CHECK_MS    = 32'd2000;
  localparam logic [31:0] IDLE_MS     = 32'd30000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_MAX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WARN_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL1_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL2_MIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL4_MIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL5_MIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL6_MIN = 3'd6;

  // reset limits (raw sample sums)
  localparam logic [SUM_W-1:0] CUTOFF_MAX_RST = 14'd4882;
  localparam logic [SUM_W-1:0] WARN_MAX_RST   = 14'd5340;
  localparam logic [SUM_W-1:0] LEVEL1_MIN_RST = 14'd6867;
  localparam logic [SUM_W-1:0] LEVEL2_MIN_RST = 14'd6104;
  localparam logic [SUM_W-1:0] LEVEL4_MIN_RST = 14'd4731;
  localparam logic [SUM_W-1:0] LEVEL5_MIN_RST = 14'd4578;
  localparam logic [SUM_W-1:0] LEVEL6_MIN_RST = 14'd4425;

  // battery level codes
  localparam logic [LVL_W-1:0] LVL_NONE = 3'd0;
  localparam logic [LVL_W-1:0] LVL_1    = 3'd1;
  localparam logic [LVL_W-1:0] LVL_2    = 3'd2;
  localparam logic [LVL_W-1:0] LVL_3    = 3'd3;
  localparam logic [LVL_W-1:0] LVL_4    = 3'd4;
  localparam logic [LVL_W-1:0] LVL_5    = 3'd5;
  localparam logic [LVL_W-1:0] LVL_6    = 3'd6;
  localparam logic [LVL_W-1:0] LVL_7    = 3'd7;

endpackage

### rtl/core/battery_power_switch_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_power_switch_controller
// Button debounce, power on/off, low battery and host idle shutdown, red LED
// and battery level code, one control-loop pass per input beat.
// ----------------------------------------------------------------------------
// One input beat is one pass of the control loop and yields exactly one
// result beat, one beat per cycle unless the result side stalls. The beat
// lands in an input register, then one pass of compare logic updates the
// controller state, which is the result register itself. The input register
// also lets one beat be taken while a result is still stalled. Timestamps are
// TIME_BITS wide internally and compared modulo 2^TIME_BITS. Write threshold
// registers via cfg_* only while the block is idle; the block does not check.
module battery_power_switch_controller
  import bpsc_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [NOW_W-1:0]     in_now_ms,
  input  logic [SUM_W-1:0]     in_sample_sum,
  input  logic                 in_button_level,
  input  logic                 in_host_idle,
  // result channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_power_out,
  output logic                 out_green_led,
  output logic                 out_red_led,
  output logic [LVL_W-1:0]     out_level_code,
  output logic                 out_host_echo,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SUM_W-1:0]     cfg_wdata
);

  typedef logic [TIME_BITS-1:0] time_t;

  localparam time_t DEBOUNCE_T = TIME_BITS'(DEBOUNCE_MS);
  localparam time_t HOLD_T     = TIME_BITS'(HOLD_MS);
  localparam time_t CHECK_T    = TIME_BITS'(CHECK_MS);
  localparam time_t IDLE_T     = TIME_BITS'(IDLE_MS);
  localparam time_t ZERO_T     = '0;

  // configuration registers
  logic [SUM_W-1:0] cutoff_max_r, warn_max_r, level1_min_r, level2_min_r;
  logic [SUM_W-1:0] level4_min_r, level5_min_r, level6_min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_max_r <= CUTOFF_MAX_RST;
      warn_max_r   <= WARN_MAX_RST;
      level1_min_r <= LEVEL1_MIN_RST;
      level2_min_r <= LEVEL2_MIN_RST;
      level4_min_r <= LEVEL4_MIN_RST;
      level5_min_r <= LEVEL5_MIN_RST;
      level6_min_r <= LEVEL6_MIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CUTOFF_MAX: cutoff_max_r <= cfg_wdata;
        REG_WARN_MAX:   warn_max_r   <= cfg_wdata;
        REG_LEVEL1_MIN: level1_min_r <= cfg_wdata;
        REG_LEVEL2_MIN: level2_min_r <= cfg_wdata;
        REG_LEVEL4_MIN: level4_min_r <= cfg_wdata;
        REG_LEVEL5_MIN: level5_min_r <= cfg_wdata;
        REG_LEVEL6_MIN: level6_min_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // handshake: input register in front, state acts as result register
  logic             in_valid_r, out_valid_r;
  time_t            in_now_r;
  logic [SUM_W-1:0] in_sum_r;
  logic             in_btn_r, in_idle_r;
  logic             advance, upd;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || advance;
  assign upd      = advance && in_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_now_r  <= TIME_BITS'(in_now_ms);
      in_sum_r  <= in_sample_sum;
      in_btn_r  <= in_button_level;
      in_idle_r <= in_host_idle;
    end
  end

  // controller state
  logic             power_on_r, warn_enable_r, red_state_r, press_pending_r;
  logic             prev_button_r, host_echo_r;
  time_t            last_edge_r, hold_start_r, last_check_r, idle_start_r;
  logic [LVL_W-1:0] level_r;

  logic             power_on_nxt, warn_enable_nxt, red_state_nxt, press_pending_nxt;
  logic             prev_button_nxt, host_echo_nxt;
  time_t            last_edge_nxt, hold_start_nxt, last_check_nxt, idle_start_nxt;
  logic [LVL_W-1:0] level_nxt;

  logic low;
  assign low = in_sum_r <= cutoff_max_r;

  function automatic logic [LVL_W-1:0] level_of(input logic [SUM_W-1:0] sum,
                                                input logic [SUM_W-1:0] l1,
                                                input logic [SUM_W-1:0] l2,
                                                input logic [SUM_W-1:0] wmax,
                                                input logic [SUM_W-1:0] l4,
                                                input logic [SUM_W-1:0] l5,
                                                input logic [SUM_W-1:0] l6);
    logic [LVL_W-1:0] code;
    priority if (sum >= l1)  code = LVL_1;
    else if (sum >= l2)      code = LVL_2;
    else if (sum > wmax)     code = LVL_3;
    else if (sum >= l4)      code = LVL_4;
    else if (sum >= l5)      code = LVL_5;
    else if (sum >= l6)      code = LVL_6;
    else                     code = LVL_7;
    return code;
  endfunction

  always_comb begin
    power_on_nxt      = power_on_r;
    warn_enable_nxt   = warn_enable_r;
    red_state_nxt     = red_state_r;
    press_pending_nxt = press_pending_r;
    prev_button_nxt   = in_btn_r;
    host_echo_nxt     = host_echo_r;
    last_edge_nxt     = last_edge_r;
    hold_start_nxt    = hold_start_r;
    last_check_nxt    = last_check_r;
    idle_start_nxt    = idle_start_r;
    level_nxt         = level_r;

    // debounce rising edges
    if (in_btn_r && !prev_button_r) begin
      if ((in_now_r - last_edge_r) > DEBOUNCE_T) begin
        press_pending_nxt = 1'b1;
      end
      last_edge_nxt = in_now_r;
    end
    if (!in_btn_r) begin
      hold_start_nxt = ZERO_T;
    end

    // press handling; zero hold start means not started
    if (!power_on_r && press_pending_nxt) begin
      press_pending_nxt = 1'b0;
      if (!low) begin
        power_on_nxt    = 1'b1;
        red_state_nxt   = 1'b0;
        warn_enable_nxt = 1'b1;
      end else begin
        warn_enable_nxt = !warn_enable_r;
      end
    end else if (power_on_r && press_pending_nxt) begin
      if (hold_start_nxt != ZERO_T && (in_now_r - hold_start_nxt) > HOLD_T) begin
        press_pending_nxt = 1'b0;
        power_on_nxt      = 1'b0;
        warn_enable_nxt   = 1'b0;
      end else if (hold_start_nxt == ZERO_T) begin
        hold_start_nxt = in_now_r;
      end
    end

    // periodic update
    if ((in_now_r - last_check_r) > CHECK_T) begin
      if (low && power_on_nxt) begin
        power_on_nxt    = 1'b0;
        warn_enable_nxt = 1'b1;
      end
      if (power_on_nxt && in_idle_r) begin
        if (idle_start_r == ZERO_T) begin
          idle_start_nxt = in_now_r;
        end else if ((in_now_r - idle_start_r) > IDLE_T) begin
          power_on_nxt    = 1'b0;
          warn_enable_nxt = 1'b1;
        end
      end else begin
        idle_start_nxt = ZERO_T;
      end
      if (warn_enable_nxt && low) begin
        red_state_nxt = !red_state_nxt;
      end else if (warn_enable_nxt && in_sum_r <= warn_max_r) begin
        red_state_nxt = 1'b1;
      end else begin
        red_state_nxt = 1'b0;
      end
      level_nxt      = level_of(in_sum_r, level1_min_r, level2_min_r, warn_max_r,
                                level4_min_r, level5_min_r, level6_min_r);
      host_echo_nxt  = in_idle_r;
      last_check_nxt = in_now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_on_r      <= 1'b0;
      warn_enable_r   <= 1'b0;
      red_state_r     <= 1'b0;
      press_pending_r <= 1'b0;
      prev_button_r   <= 1'b0;
      host_echo_r     <= 1'b0;
      last_edge_r     <= ZERO_T;
      hold_start_r    <= ZERO_T;
      last_check_r    <= ZERO_T;
      idle_start_r    <= ZERO_T;
      level_r         <= LVL_NONE;
    end else if (upd) begin
      power_on_r      <= power_on_nxt;
      warn_enable_r   <= warn_enable_nxt;
      red_state_r     <= red_state_nxt;
      press_pending_r <= press_pending_nxt;
      prev_button_r   <= prev_button_nxt;
      host_echo_r     <= host_echo_nxt;
      last_edge_r     <= last_edge_nxt;
      hold_start_r    <= hold_start_nxt;
      last_check_r    <= last_check_nxt;
      idle_start_r    <= idle_start_nxt;
      level_r         <= level_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_power_out  = power_on_r;
  assign out_green_led  = power_on_r;
  assign out_red_led    = red_state_r;
  assign out_level_code = level_r;
  assign out_host_echo  = host_echo_r;

  // once a level is reported it never returns to the no-update code
  a_level_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    level_r != LVL_NONE |=> level_r != LVL_NONE)
    else $error("level code returned to none");

  // power comes up only together with warning enable
  a_power_on_warn: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(power_on_r) |-> warn_enable_r)
    else $error("power on without warning enable");

  // a held input beat is not dropped while the result side stalls
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_now_r))
    else $error("input beat lost under stall");

endmodule

### dv/bpsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsc_checker: scoreboard for the battery power switch controller
// Watches the input, result and configuration ports, runs its own copy of the
// control loop for every accepted input beat and compares each result beat
// field by field against the oldest predicted status.
// ----------------------------------------------------------------------------
module bpsc_checker
  import bpsc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [NOW_W-1:0]     in_now_ms,
  input  logic [SUM_W-1:0]     in_sample_sum,
  input  logic                 in_button_level,
  input  logic                 in_host_idle,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 out_power_out,
  input  logic                 out_green_led,
  input  logic                 out_red_led,
  input  logic [LVL_W-1:0]     out_level_code,
  input  logic                 out_host_echo,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SUM_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   pending,
  output int                   passes_checked,
  output int                   power_ups,
  output logic [7:0]           levels_seen
);

  typedef struct packed {
    logic             power;
    logic             green;
    logic             red;
    logic [LVL_W-1:0] level;
    logic             echo;
  } status_t;

  status_t status_q[$];

  // threshold copy
  logic [SUM_W-1:0] lim_cutoff, lim_warn, lim_lvl1, lim_lvl2, lim_lvl4, lim_lvl5, lim_lvl6;

  // controller state copy
  logic        power_on, warn_enable, red_state, press_pending, prev_btn, host_echo_reg;
  logic [31:0] last_edge_ms, hold_start_ms, last_check_ms, idle_start_ms;
  logic [LVL_W-1:0] level_reg;

  function automatic void reset_model();
    lim_cutoff    = CUTOFF_MAX_RST;
    lim_warn      = WARN_MAX_RST;
    lim_lvl1      = LEVEL1_MIN_RST;
    lim_lvl2      = LEVEL2_MIN_RST;
    lim_lvl4      = LEVEL4_MIN_RST;
    lim_lvl5      = LEVEL5_MIN_RST;
    lim_lvl6      = LEVEL6_MIN_RST;
    power_on      = 1'b0;
    warn_enable   = 1'b0;
    red_state     = 1'b0;
    press_pending = 1'b0;
    prev_btn      = 1'b0;
    host_echo_reg = 1'b0;
    last_edge_ms  = '0;
    hold_start_ms = '0;
    last_check_ms = '0;
    idle_start_ms = '0;
    level_reg     = LVL_NONE;
  endfunction

  function automatic void apply_limit(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [SUM_W-1:0] val);
    case (idx)
      REG_CUTOFF_MAX: lim_cutoff = val;
      REG_WARN_MAX:   lim_warn   = val;
      REG_LEVEL1_MIN: lim_lvl1   = val;
      REG_LEVEL2_MIN: lim_lvl2   = val;
      REG_LEVEL4_MIN: lim_lvl4   = val;
      REG_LEVEL5_MIN: lim_lvl5   = val;
      REG_LEVEL6_MIN: lim_lvl6   = val;
      default: ;
    endcase
  endfunction

  function automatic logic [LVL_W-1:0] battery_level(input logic [SUM_W-1:0] sum);
    if (sum >= lim_lvl1) return LVL_1;
    if (sum >= lim_lvl2) return LVL_2;
    if (sum > lim_warn) return LVL_3;
    if (sum >= lim_lvl4) return LVL_4;
    if (sum >= lim_lvl5) return LVL_5;
    if (sum >= lim_lvl6) return LVL_6;
    return LVL_7;
  endfunction

  // turning on also re-arms the warning and darkens the red LED
  function automatic void switch_power(input logic on);
    if (on && !power_on) power_ups++;
    power_on = on;
    if (on) begin
      red_state   = 1'b0;
      warn_enable = 1'b1;
    end
  endfunction

  function automatic status_t control_pass(input logic [31:0] now,
                                           input logic [SUM_W-1:0] sum,
                                           input logic btn,
                                           input logic idle);
    logic    low;
    status_t st;
    low = (sum <= lim_cutoff);

    // all time differences wrap at 32 bits
    if (btn && !prev_btn) begin
      if (32'(now - last_edge_ms) > DEBOUNCE_MS) press_pending = 1'b1;
      last_edge_ms = now;
    end
    prev_btn = btn;
    if (!btn) hold_start_ms = '0;

    if (!power_on && press_pending) begin
      press_pending = 1'b0;
      if (!low) switch_power(1'b1);
      else warn_enable = !warn_enable;
    end else if (power_on && press_pending) begin
      if (hold_start_ms != 0 && 32'(now - hold_start_ms) > HOLD_MS) begin
        press_pending = 1'b0;
        switch_power(1'b0);
        warn_enable = 1'b0;
      end else if (hold_start_ms == 0) begin
        // a start taken at time zero reads as not started
        hold_start_ms = now;
      end
    end

    if (32'(now - last_check_ms) > CHECK_MS) begin
      if (low && power_on) begin
        switch_power(1'b0);
        warn_enable = 1'b1;
      end
      if (power_on && idle) begin
        if (idle_start_ms == 0) begin
          idle_start_ms = now;
        end else if (32'(now - idle_start_ms) > IDLE_MS) begin
          switch_power(1'b0);
          warn_enable = 1'b1;
        end
      end else begin
        idle_start_ms = '0;
      end
      if (warn_enable && low) red_state = !red_state;
      else if (warn_enable && sum <= lim_warn) red_state = 1'b1;
      else red_state = 1'b0;
      level_reg     = battery_level(sum);
      host_echo_reg = idle;
      last_check_ms = now;
    end

    st.power = power_on;
    st.green = power_on;
    st.red   = red_state;
    st.level = level_reg;
    st.echo  = host_echo_reg;
    return st;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    status_t want;
    if (!rst_n) begin
      reset_model();
      status_q.delete();
      levels_seen = '0;
    end else begin
      if (cfg_we) apply_limit(cfg_index, cfg_wdata);
      // a result beat can never belong to the input beat of the same edge
      if (out_valid && out_ready) begin
        if (status_q.size() == 0) begin
          $error("result beat with no control pass outstanding");
          fail_count++;
        end else begin
          want = status_q.pop_front();
          check_field("power_out", want.power, out_power_out);
          check_field("green_led", want.green, out_green_led);
          check_field("red_led", want.red, out_red_led);
          check_field("level_code", want.level, out_level_code);
          check_field("host_echo", want.echo, out_host_echo);
          levels_seen[want.level] = 1'b1;
          passes_checked++;
        end
      end
      if (in_valid && in_ready)
        status_q.push_back(control_pass(in_now_ms, in_sample_sum, in_button_level,
                                        in_host_idle));
    end
    pending <= status_q.size();
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: battery power switch controller testbench
// Drives control-loop passes (directed corner cases, then press/hold, idle,
// button chatter and timestamp-jump traffic) across several threshold
// settings with random stalls on both channels; bpsc_checker scores results.
// ----------------------------------------------------------------------------
module tb;
  import bpsc_pkg::*;

  localparam int               CYCLE_LIMIT    = 500000;
  localparam int               PHASE_BEATS    = 170;
  localparam int               LONG_STALL     = 300;
  localparam logic [SUM_W-1:0] SUM_MAX        = 14'd9207;
  localparam logic [SUM_W-1:0] SUM_ALL_ONES   = 14'h3FFF;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [NOW_W-1:0]     in_now_ms;
  logic [SUM_W-1:0]     in_sample_sum;
  logic                 in_button_level;
  logic                 in_host_idle;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_power_out;
  logic                 out_green_led;
  logic                 out_red_led;
  logic [LVL_W-1:0]     out_level_code;
  logic                 out_host_echo;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SUM_W-1:0]     cfg_wdata;

  int         fail_count;
  int         pending;
  int         passes_checked;
  int         power_ups;
  logic [7:0] levels_seen;

  int               cycle_count;
  int               beats_sent;
  int               settings_loaded;
  logic             steady;
  logic             stall_request;
  logic [31:0]      ms_now;
  logic [SUM_W-1:0] limits [7];

  battery_power_switch_controller DUT (.*);

  bpsc_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: mostly ready, short and occasional long stalls, one forced hold-off
  initial begin
    int r, n;
    out_ready <= 1'b0;
    forever begin
      if (stall_request) begin
        stall_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_ready <= 1'b1;
          n = $urandom_range(1, 8);
        end else if (r < 70) begin
          out_ready <= 1'b1;
          n = $urandom_range(50, 150);
        end else if (r < 95) begin
          out_ready <= 1'b0;
          n = $urandom_range(1, 3);
        end else begin
          out_ready <= 1'b0;
          n = $urandom_range(10, 40);
        end
        repeat (n) @(posedge clk);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // sums cluster around the live thresholds, with the odd out-of-range value
  function automatic logic [SUM_W-1:0] pick_sum();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return SUM_W'(limits[$urandom_range(0, 6)] + $urandom_range(0, 4) - 2);
    if (r < 8) return SUM_W'($urandom_range(0, SUM_MAX));
    if (r < 9) return SUM_W'($urandom_range(0, SUM_ALL_ONES));
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return SUM_MAX;
      default: return SUM_ALL_ONES;
    endcase
  endfunction

  function automatic logic [SUM_W-1:0] drift_sum(input logic [SUM_W-1:0] base);
    if ($urandom_range(0, 3) == 0) return pick_sum();
    return SUM_W'(base + $urandom_range(0, 40) - 20);
  endfunction

  // one control-loop pass: hold valid until the beat is taken
  task automatic apply_pass(input logic [31:0] now, input logic [SUM_W-1:0] sum,
                            input logic btn, input logic idle);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_now_ms       <= now;
    in_sample_sum   <= sum;
    in_button_level <= btn;
    in_host_idle    <= idle;
    ms_now = now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SUM_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic load_limits(input logic poke_unused);
    write_reg(REG_CUTOFF_MAX, limits[0]);
    write_reg(REG_WARN_MAX, limits[1]);
    write_reg(REG_LEVEL1_MIN, limits[2]);
    write_reg(REG_LEVEL2_MIN, limits[3]);
    write_reg(REG_LEVEL4_MIN, limits[4]);
    write_reg(REG_LEVEL5_MIN, limits[5]);
    write_reg(REG_LEVEL6_MIN, limits[6]);
    if (poke_unused) write_reg(REG_UNUSED, SUM_W'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_loaded++;
  endtask

  task automatic reset_limits();
    limits[0] = CUTOFF_MAX_RST;
    limits[1] = WARN_MAX_RST;
    limits[2] = LEVEL1_MIN_RST;
    limits[3] = LEVEL2_MIN_RST;
    limits[4] = LEVEL4_MIN_RST;
    limits[5] = LEVEL5_MIN_RST;
    limits[6] = LEVEL6_MIN_RST;
  endtask

  // stop offering and wait out every outstanding result plus pipeline slack
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_directed();
    apply_pass(32'd0, 14'd5000, 1'b0, 1'b0);
    apply_pass(32'd0, 14'd5000, 1'b1, 1'b0);       // edge too soon after time zero
    apply_pass(32'd30, 14'd5000, 1'b0, 1'b0);
    apply_pass(32'd100, SUM_MAX, 1'b1, 1'b0);      // press, power on
    apply_pass(32'd2101, SUM_MAX, 1'b0, 1'b1);     // first update, level 1
    apply_pass(32'd2200, SUM_MAX, 1'b1, 1'b0);     // press while on, hold starts
    apply_pass(32'd4000, SUM_MAX, 1'b1, 1'b0);
    apply_pass(32'd5201, 14'd5000, 1'b1, 1'b0);    // hold past 3 s, power off
    apply_pass(32'd5300, 14'd5000, 1'b0, 1'b0);
    apply_pass(32'd5400, 14'd4882, 1'b1, 1'b0);    // press at cutoff: warn toggles
    apply_pass(32'd7500, 14'd4882, 1'b0, 1'b0);    // red blinks
    apply_pass(32'd9600, 14'd4882, 1'b0, 1'b0);
    apply_pass(32'd11700, 14'd5340, 1'b0, 1'b0);   // at warning limit: red lit
    apply_pass(32'd11800, 14'd5341, 1'b1, 1'b0);
    apply_pass(32'd13801, 14'd4000, 1'b0, 1'b0);   // low battery shutdown, level 7
    apply_pass(32'd13900, SUM_ALL_ONES, 1'b1, 1'b0);
    apply_pass(32'd16000, 14'd6104, 1'b0, 1'b1);   // idle timer starts, level 2
    apply_pass(32'd47000, 14'd6867, 1'b0, 1'b1);   // idle shutdown
    apply_pass(32'hFFFF_F000, 14'd4425, 1'b0, 1'b0);
    apply_pass(32'hFFFF_F100, 14'd8000, 1'b1, 1'b0);
    apply_pass(32'hFFFF_FFF0, 14'd5500, 1'b0, 1'b0); // level 3
    apply_pass(32'd0, 14'd4578, 1'b1, 1'b0);       // hold taken at zero stays unset
    apply_pass(32'h100, 14'd4578, 1'b1, 1'b0);
    apply_pass(32'hD00, 14'd4578, 1'b1, 1'b1);     // hold off across the wrap
  endtask

  task automatic run_session();
    int               len, hold_from, hold_to, i;
    logic             idle_on;
    logic [SUM_W-1:0] base;
    len       = $urandom_range(4, 45);
    base      = pick_sum();
    idle_on   = ($urandom_range(0, 2) == 0);
    hold_from = $urandom_range(0, 2);
    hold_to   = hold_from + (($urandom_range(0, 3) == 0) ? $urandom_range(5, 12)
                                                         : $urandom_range(0, 2));
    for (i = 0; i < len; i++) begin
      if (idle_on) ms_now = ms_now + $urandom_range(300, 1800);
      else ms_now = ms_now + $urandom_range(60, 900);
      apply_pass(ms_now, drift_sum(base), (i >= hold_from && i <= hold_to),
                 idle_on ^ ($urandom_range(0, 15) == 0));
    end
  endtask

  task automatic run_chatter();
    int               len, i;
    logic [SUM_W-1:0] base;
    len  = $urandom_range(4, 12);
    base = pick_sum();
    for (i = 0; i < len; i++) begin
      ms_now = ms_now + $urandom_range(1, 70);
      apply_pass(ms_now, drift_sum(base), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_noise();
    int len, i;
    len = $urandom_range(3, 6);
    for (i = 0; i < len; i++) begin
      case ($urandom_range(0, 5))
        0:       ms_now = '0;
        1:       ms_now = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        2:       ms_now = $urandom;
        default: ms_now = ms_now + $urandom_range(0, 5000);
      endcase
      apply_pass(ms_now, SUM_W'($urandom_range(0, SUM_ALL_ONES)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    int phase, target, r, i;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_now_ms       <= '0;
    in_sample_sum   <= '0;
    in_button_level <= 1'b0;
    in_host_idle    <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_CUTOFF_MAX;
    cfg_wdata       <= '0;
    beats_sent      = 0;
    settings_loaded = 0;
    steady          = 1'b0;
    stall_request   = 1'b0;
    ms_now          = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    reset_limits();
    load_limits(1'b0);
    run_directed();
    drain();

    for (phase = 1; phase <= 6; phase++) begin
      case (phase)
        1: for (i = 0; i < 7; i++) limits[i] = SUM_W'($urandom_range(0, SUM_MAX));
        2: for (i = 0; i < 7; i++) limits[i] = '0;
        3: for (i = 0; i < 7; i++) limits[i] = SUM_MAX;
        4: for (i = 0; i < 7; i++) limits[i] = SUM_ALL_ONES;
        5: for (i = 0; i < 7; i++) limits[i] = SUM_W'($urandom_range(0, SUM_ALL_ONES));
        default: reset_limits();
      endcase
      load_limits(phase == 5);
      if (phase == 4) ms_now = 32'hFFFF_F000;
      // receiver goes away for a while; the sender keeps pushing until it backs up
      if (phase == 1) stall_request = 1'b1;
      target = beats_sent + PHASE_BEATS;
      while (beats_sent < target) begin
        steady = ($urandom_range(0, 4) == 0);
        r = $urandom_range(0, 99);
        if (r < 55) run_session();
        else if (r < 80) run_chatter();
        else run_noise();
      end
      steady = 1'b0;
      drain();
    end

    repeat (10) @(posedge clk);
    $display("Checked %0d control passes over %0d threshold settings, %0d power-ups.",
             passes_checked, settings_loaded, power_ups);
    $display("Level codes reported (one bit per code): %b", levels_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
